>>> rtl/core/aaline_pkg.sv
package aaline_pkg;

    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 16;
    localparam int OUT_BITS     = COORD_BITS + 1;
    localparam int WEIGHT_BITS  = 9;
    localparam int LOW_W_BITS   = 8;
    localparam int DIV_BITS     = COORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
    localparam int MAG_BITS     = FRAC_BITS + 1;
    localparam int SLOPE_BITS   = FRAC_BITS + 2;
    localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 1;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL = WEIGHT_BITS'(256);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_HALF = WEIGHT_BITS'(128);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_NONE = WEIGHT_BITS'(0);

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ORDER,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_LAST,
        PH_INTERIOR
    } phase_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic order;
        logic div_step;
        logic finish;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic line_active;
    } dp_status_t;

endpackage

>>> rtl/core/aaline_ctrl.sv
module aaline_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_action,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  aaline_pkg::dp_status_t status,
    output aaline_pkg::dp_cmd_t    cmd
);
    import aaline_pkg::*;

    state_t                  state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACTION_LOAD) begin
                        cmd.load   = 1'b1;
                        state_next = ST_PREP;
                    end else if (status.line_active) begin
                        cmd.step     = 1'b1;
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_ORDER;
            end
            ST_ORDER: begin
                cmd.order  = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_BITS'(1);
                if (cnt_reg == DIV_CNT_BITS'(DIV_BITS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/aaline_dpath.sv
module aaline_dpath (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  aaline_pkg::dp_cmd_t                       cmd,
    output aaline_pkg::dp_status_t                    status,
    input  logic [aaline_pkg::COORD_BITS-1:0]         s_start_x,
    input  logic [aaline_pkg::COORD_BITS-1:0]         s_start_y,
    input  logic [aaline_pkg::COORD_BITS-1:0]         s_end_x,
    input  logic [aaline_pkg::COORD_BITS-1:0]         s_end_y,
    output logic [aaline_pkg::OUT_BITS-1:0]           m_upper_px,
    output logic [aaline_pkg::OUT_BITS-1:0]           m_upper_py,
    output logic [aaline_pkg::WEIGHT_BITS-1:0]        m_upper_weight,
    output logic [aaline_pkg::OUT_BITS-1:0]           m_lower_px,
    output logic [aaline_pkg::OUT_BITS-1:0]           m_lower_py,
    output logic [aaline_pkg::WEIGHT_BITS-1:0]        m_lower_weight,
    output logic                                      m_last_column
);
    import aaline_pkg::*;

    logic [COORD_BITS-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic [COORD_BITS-1:0]  amj_reg, amn_reg, bmj_reg, bmn_reg;
    logic                   steep_reg, neg_reg, line_active_reg;
    phase_t                 phase_reg;
    logic [OUT_BITS-1:0]    major_pos_reg;
    logic [COORD_BITS-1:0]  major_end_reg, first_minor_reg, last_minor_reg, dx_reg;
    logic [COORD_BITS-1:0]  rem_reg, rem_next;
    logic [DIV_BITS-1:0]    dvd_reg;
    logic [SLOPE_BITS-1:0]  slope_reg;
    logic [ACC_BITS-1:0]    acc_reg;

    logic [OUT_BITS-1:0]    up_px_reg, up_py_reg, lo_px_reg, lo_py_reg;
    logic [WEIGHT_BITS-1:0] up_w_reg, lo_w_reg;
    logic                   last_reg;

    // prep
    logic [COORD_BITS-1:0]  adx, ady;
    logic                   steep_next;
    // order
    logic                   swap;
    logic [COORD_BITS-1:0]  mj_lo, mj_hi, mn_lo, mn_hi, dy_mag;
    // divide
    logic [COORD_BITS:0]    rem_shift;
    logic [COORD_BITS+1:0]  rem_diff;
    logic                   q_bit;
    // finish
    logic [MAG_BITS-1:0]    mag;
    logic [SLOPE_BITS-1:0]  slope_next;
    logic [ACC_BITS-1:0]    slope_ext;
    // column
    logic [ACC_BITS-1:0]    acc_clamp;
    logic [COORD_BITS-1:0]  int_minor;
    logic [LOW_W_BITS-1:0]  int_low_w;
    logic [OUT_BITS-1:0]    major_inc, col_major, col_minor, col_minor1;
    logic [WEIGHT_BITS-1:0] col_up_w, col_lo_w;
    logic                   col_last;

    assign adx        = (ax_reg > bx_reg) ? ax_reg - bx_reg : bx_reg - ax_reg;
    assign ady        = (ay_reg > by_reg) ? ay_reg - by_reg : by_reg - ay_reg;
    assign steep_next = ady > adx;

    assign swap   = amj_reg > bmj_reg;
    assign mj_lo  = swap ? bmj_reg : amj_reg;
    assign mj_hi  = swap ? amj_reg : bmj_reg;
    assign mn_lo  = swap ? bmn_reg : amn_reg;
    assign mn_hi  = swap ? amn_reg : bmn_reg;
    assign dy_mag = (mn_hi < mn_lo) ? mn_lo - mn_hi : mn_hi - mn_lo;

    assign rem_shift = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, dx_reg};
    assign q_bit     = !rem_diff[COORD_BITS+1];
    assign rem_next  = q_bit ? rem_diff[COORD_BITS-1:0] : rem_shift[COORD_BITS-1:0];

    assign mag        = (dx_reg == '0) ? MAG_BITS'(1) << FRAC_BITS : dvd_reg[MAG_BITS-1:0];
    assign slope_next = neg_reg ? -{1'b0, mag} : {1'b0, mag};
    assign slope_ext  = {{(ACC_BITS-SLOPE_BITS){slope_reg[SLOPE_BITS-1]}}, slope_reg};

    assign acc_clamp = acc_reg[ACC_BITS-1] ? '0 : acc_reg;
    assign int_minor = acc_clamp[FRAC_BITS +: COORD_BITS];
    assign int_low_w = acc_clamp[FRAC_BITS-LOW_W_BITS +: LOW_W_BITS];
    assign major_inc = major_pos_reg + OUT_BITS'(1);

    always_comb begin
        col_major = major_pos_reg;
        col_minor = {1'b0, first_minor_reg};
        col_up_w  = WEIGHT_HALF;
        col_lo_w  = WEIGHT_NONE;
        col_last  = 1'b0;
        case (phase_reg)
            PH_FIRST: begin
                col_last = 1'b0;
            end
            PH_LAST: begin
                col_major = {1'b0, major_end_reg};
                col_minor = {1'b0, last_minor_reg};
                col_last  = major_pos_reg >= {1'b0, major_end_reg};
            end
            PH_INTERIOR: begin
                col_minor = {1'b0, int_minor};
                col_lo_w  = {1'b0, int_low_w};
                col_up_w  = WEIGHT_FULL - {1'b0, int_low_w};
                col_last  = major_inc >= {1'b0, major_end_reg};
            end
            default: begin
                col_last = 1'b0;
            end
        endcase
    end

    assign col_minor1 = col_minor + OUT_BITS'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            phase_reg       <= PH_FIRST;
        end else begin
            if (cmd.load) begin
                line_active_reg <= 1'b0;
            end else if (cmd.finish) begin
                line_active_reg <= 1'b1;
                phase_reg       <= PH_FIRST;
            end else if (cmd.step) begin
                case (phase_reg)
                    PH_FIRST: phase_reg <= PH_LAST;
                    PH_LAST: begin
                        if (col_last) begin
                            line_active_reg <= 1'b0;
                        end else begin
                            phase_reg <= PH_INTERIOR;
                        end
                    end
                    default: begin
                        if (col_last) begin
                            line_active_reg <= 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg <= s_start_x;
            ay_reg <= s_start_y;
            bx_reg <= s_end_x;
            by_reg <= s_end_y;
        end
        if (cmd.prep) begin
            steep_reg <= steep_next;
            amj_reg   <= steep_next ? ay_reg : ax_reg;
            amn_reg   <= steep_next ? ax_reg : ay_reg;
            bmj_reg   <= steep_next ? by_reg : bx_reg;
            bmn_reg   <= steep_next ? bx_reg : by_reg;
        end
        if (cmd.order) begin
            major_pos_reg   <= {1'b0, mj_lo};
            major_end_reg   <= mj_hi;
            first_minor_reg <= mn_lo;
            last_minor_reg  <= mn_hi;
            dx_reg          <= mj_hi - mj_lo;
            neg_reg         <= mn_hi < mn_lo;
            dvd_reg         <= {dy_mag, {FRAC_BITS{1'b0}}};
            rem_reg         <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DIV_BITS-2:0], q_bit};
        end
        if (cmd.finish) begin
            slope_reg <= slope_next;
            acc_reg   <= {1'b0, first_minor_reg, {FRAC_BITS{1'b0}}}
                         + {{(ACC_BITS-SLOPE_BITS){slope_next[SLOPE_BITS-1]}}, slope_next};
        end
        if (cmd.step) begin
            if (phase_reg == PH_FIRST) begin
                major_pos_reg <= major_inc;
            end else if (phase_reg == PH_INTERIOR) begin
                major_pos_reg <= major_inc;
                acc_reg       <= acc_reg + slope_ext;
            end
            if (steep_reg) begin
                up_px_reg <= col_minor;
                up_py_reg <= col_major;
                lo_px_reg <= col_minor1;
                lo_py_reg <= col_major;
            end else begin
                up_px_reg <= col_major;
                up_py_reg <= col_minor;
                lo_px_reg <= col_major;
                lo_py_reg <= col_minor1;
            end
            up_w_reg <= col_up_w;
            lo_w_reg <= col_lo_w;
            last_reg <= col_last;
        end
    end

    assign status.line_active = line_active_reg;

    assign m_upper_px     = up_px_reg;
    assign m_upper_py     = up_py_reg;
    assign m_upper_weight = up_w_reg;
    assign m_lower_px     = lo_px_reg;
    assign m_lower_py     = lo_py_reg;
    assign m_lower_weight = lo_w_reg;
    assign m_last_column  = last_reg;

endmodule

>>> rtl/core/antialiased_line_coverage_gen.sv
// Step transaction: the column is registered and appears on the m_ side in the cycle after acceptance;
// one step per cycle while the output is taken.
// Load transaction: the next input is not taken until the controller has passed through PREP,
// ORDER, the restoring gradient divider in DIV (one quotient bit per cycle) and FINISH.
// Reset (aresetn low, synchronous) clears the controller, output valid and the active line.
module antialiased_line_coverage_gen (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_action,
    input  logic [aaline_pkg::COORD_BITS-1:0]   s_start_x,
    input  logic [aaline_pkg::COORD_BITS-1:0]   s_start_y,
    input  logic [aaline_pkg::COORD_BITS-1:0]   s_end_x,
    input  logic [aaline_pkg::COORD_BITS-1:0]   s_end_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [aaline_pkg::OUT_BITS-1:0]     m_upper_px,
    output logic [aaline_pkg::OUT_BITS-1:0]     m_upper_py,
    output logic [aaline_pkg::WEIGHT_BITS-1:0]  m_upper_weight,
    output logic [aaline_pkg::OUT_BITS-1:0]     m_lower_px,
    output logic [aaline_pkg::OUT_BITS-1:0]     m_lower_py,
    output logic [aaline_pkg::WEIGHT_BITS-1:0]  m_lower_weight,
    output logic                                m_last_column
);
    import aaline_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    aaline_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    aaline_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .m_upper_px     (m_upper_px),
        .m_upper_py     (m_upper_py),
        .m_upper_weight (m_upper_weight),
        .m_lower_px     (m_lower_px),
        .m_lower_py     (m_lower_py),
        .m_lower_weight (m_lower_weight),
        .m_last_column  (m_last_column)
    );

endmodule

>>> rtl/core/aaline_checker.sv
module aaline_port_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_action,
    input  logic [aaline_pkg::COORD_BITS-1:0]   s_start_x,
    input  logic [aaline_pkg::COORD_BITS-1:0]   s_start_y,
    input  logic [aaline_pkg::COORD_BITS-1:0]   s_end_x,
    input  logic [aaline_pkg::COORD_BITS-1:0]   s_end_y,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [aaline_pkg::OUT_BITS-1:0]     m_upper_px,
    input  logic [aaline_pkg::OUT_BITS-1:0]     m_upper_py,
    input  logic [aaline_pkg::WEIGHT_BITS-1:0]  m_upper_weight,
    input  logic [aaline_pkg::OUT_BITS-1:0]     m_lower_px,
    input  logic [aaline_pkg::OUT_BITS-1:0]     m_lower_py,
    input  logic [aaline_pkg::WEIGHT_BITS-1:0]  m_lower_weight,
    input  logic                                m_last_column
);
    import aaline_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_upper_px) && $stable(m_upper_py)
            && $stable(m_upper_weight) && $stable(m_lower_px) && $stable(m_lower_py)
            && $stable(m_lower_weight) && $stable(m_last_column))
        else $error("stalled result changed");

    a_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && (s_action == ACTION_STEP)))
        else $error("result without an accepted step");

    a_weights: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_upper_weight + m_lower_weight == 256)
            || (m_upper_weight == 128 && m_lower_weight == 0))
        else $error("coverage weights inconsistent");

    a_adjacent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lower_px == m_upper_px && m_lower_py == m_upper_py + 1)
            || (m_lower_py == m_upper_py && m_lower_px == m_upper_px + 1))
        else $error("pixel pair not adjacent");

endmodule

bind antialiased_line_coverage_gen aaline_port_checker u_aaline_checker (.*);

>>> tb/sv/aaline_checker.sv
module aaline_checker
    import aaline_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_action,
    input  logic [COORD_BITS-1:0]  s_start_x,
    input  logic [COORD_BITS-1:0]  s_start_y,
    input  logic [COORD_BITS-1:0]  s_end_x,
    input  logic [COORD_BITS-1:0]  s_end_y,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [OUT_BITS-1:0]    m_upper_px,
    input  logic [OUT_BITS-1:0]    m_upper_py,
    input  logic [WEIGHT_BITS-1:0] m_upper_weight,
    input  logic [OUT_BITS-1:0]    m_lower_px,
    input  logic [OUT_BITS-1:0]    m_lower_py,
    input  logic [WEIGHT_BITS-1:0] m_lower_weight,
    input  logic                   m_last_column,
    output int                     mismatch_count,
    output int                     columns_due,
    output int                     columns_checked
);

    typedef struct packed {
        logic [OUT_BITS-1:0]    upper_px;
        logic [OUT_BITS-1:0]    upper_py;
        logic [WEIGHT_BITS-1:0] upper_weight;
        logic [OUT_BITS-1:0]    lower_px;
        logic [OUT_BITS-1:0]    lower_py;
        logic [WEIGHT_BITS-1:0] lower_weight;
        logic                   last_column;
    } column_t;

    column_t column_q[$];

    logic                   line_on;
    logic                   steep;
    phase_t                 phase;
    logic [OUT_BITS-1:0]    major_at;
    logic [OUT_BITS-1:0]    major_stop;
    logic [COORD_BITS-1:0]  minor_first;
    logic [COORD_BITS-1:0]  minor_last;
    logic signed [ACC_BITS-1:0]   intercept;
    logic signed [SLOPE_BITS-1:0] gradient;

    int errors;
    int checked;

    function automatic column_t make_column(input logic [OUT_BITS-1:0] major,
                                            input logic [OUT_BITS-1:0] minor,
                                            input logic [WEIGHT_BITS-1:0] up_w,
                                            input logic [WEIGHT_BITS-1:0] lo_w,
                                            input logic last);
        column_t col;
        if (steep) begin
            col.upper_px = minor;
            col.upper_py = major;
            col.lower_px = minor + 1'b1;
            col.lower_py = major;
        end else begin
            col.upper_px = major;
            col.upper_py = minor;
            col.lower_px = major;
            col.lower_py = minor + 1'b1;
        end
        col.upper_weight = up_w;
        col.lower_weight = lo_w;
        col.last_column  = last;
        return col;
    endfunction

    task automatic load_line(input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
                             input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey);
        logic [COORD_BITS-1:0] ax, ay, bx, by, tmp, adx, ady, run, rise;
        logic                  falling;
        logic [DIV_BITS-1:0]   quot;
        ax  = sx;
        ay  = sy;
        bx  = ex;
        by  = ey;
        adx = (bx > ax) ? bx - ax : ax - bx;
        ady = (by > ay) ? by - ay : ay - by;
        steep = ady > adx;
        if (steep) begin
            tmp = ax; ax = ay; ay = tmp;
            tmp = bx; bx = by; by = tmp;
        end
        if (ax > bx) begin
            tmp = ax; ax = bx; bx = tmp;
            tmp = ay; ay = by; by = tmp;
        end
        run     = bx - ax;
        falling = by < ay;
        rise    = falling ? ay - by : by - ay;
        if (run == '0) begin
            gradient = SLOPE_BITS'(1 << FRAC_BITS);
        end else begin
            quot     = {rise, {FRAC_BITS{1'b0}}} / DIV_BITS'(run);
            gradient = falling ? -SLOPE_BITS'(quot) : SLOPE_BITS'(quot);
        end
        intercept   = $signed({1'b0, ay, {FRAC_BITS{1'b0}}}) + gradient;
        minor_first = ay;
        minor_last  = by;
        major_at    = {1'b0, ax};
        major_stop  = {1'b0, bx};
        phase       = PH_FIRST;
        line_on     = 1'b1;
    endtask

    task automatic advance_line(output bit made, output column_t col);
        logic [ACC_BITS-1:0]   acc;
        logic [LOW_W_BITS-1:0] lo_w;
        logic                  fin;
        made = 1'b0;
        col  = '0;
        if (line_on) begin
            made = 1'b1;
            case (phase)
                PH_FIRST: begin
                    col      = make_column(major_at, {1'b0, minor_first},
                                           WEIGHT_HALF, WEIGHT_NONE, 1'b0);
                    phase    = PH_LAST;
                    major_at = major_at + 1'b1;
                end
                PH_LAST: begin
                    fin = major_at >= major_stop;
                    col = make_column(major_stop, {1'b0, minor_last},
                                      WEIGHT_HALF, WEIGHT_NONE, fin);
                    if (fin) begin
                        line_on = 1'b0;
                    end else begin
                        phase = PH_INTERIOR;
                    end
                end
                default: begin
                    acc  = (intercept < 0) ? '0 : intercept;
                    lo_w = acc[FRAC_BITS-1 -: LOW_W_BITS];
                    fin  = (major_at + 1'b1) >= major_stop;
                    col  = make_column(major_at, acc[ACC_BITS-1:FRAC_BITS],
                                       WEIGHT_FULL - lo_w, WEIGHT_BITS'(lo_w), fin);
                    intercept = intercept + gradient;
                    major_at  = major_at + 1'b1;
                    if (fin) begin
                        line_on = 1'b0;
                    end
                end
            endcase
        end
    endtask

    function automatic bit field_ok(input string name, input logic [OUT_BITS-1:0] want,
                                    input logic [OUT_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        column_t want;
        column_t col;
        bit      made;
        bit      ok;
        if (!aresetn) begin
            line_on     = 1'b0;
            steep       = 1'b0;
            phase       = PH_FIRST;
            major_at    = '0;
            major_stop  = '0;
            minor_first = '0;
            minor_last  = '0;
            intercept   = '0;
            gradient    = '0;
            column_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (column_q.size() == 0) begin
                    $display("%0t: column expected none actual px=%0d py=%0d last=%0d",
                             $time, m_upper_px, m_upper_py, m_last_column);
                    errors++;
                end else begin
                    want = column_q.pop_front();
                    ok = field_ok("upper_px", want.upper_px, m_upper_px);
                    ok = field_ok("upper_py", want.upper_py, m_upper_py) && ok;
                    ok = field_ok("upper_weight", OUT_BITS'(want.upper_weight),
                                  OUT_BITS'(m_upper_weight)) && ok;
                    ok = field_ok("lower_px", want.lower_px, m_lower_px) && ok;
                    ok = field_ok("lower_py", want.lower_py, m_lower_py) && ok;
                    ok = field_ok("lower_weight", OUT_BITS'(want.lower_weight),
                                  OUT_BITS'(m_lower_weight)) && ok;
                    ok = field_ok("last_column", OUT_BITS'(want.last_column),
                                  OUT_BITS'(m_last_column)) && ok;
                    if (!ok) begin
                        errors++;
                    end
                    checked++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_action == ACTION_LOAD) begin
                    load_line(s_start_x, s_start_y, s_end_x, s_end_y);
                end else begin
                    advance_line(made, col);
                    if (made) begin
                        column_q.push_back(col);
                    end
                end
            end
        end
        mismatch_count  <= errors;
        columns_due     <= column_q.size();
        columns_checked <= checked;
    end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
    import aaline_pkg::*;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_action  = ACTION_LOAD;
    logic [COORD_BITS-1:0]  s_start_x = '0;
    logic [COORD_BITS-1:0]  s_start_y = '0;
    logic [COORD_BITS-1:0]  s_end_x   = '0;
    logic [COORD_BITS-1:0]  s_end_y   = '0;
    logic                   m_ready   = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_BITS-1:0]    m_upper_px;
    logic [OUT_BITS-1:0]    m_upper_py;
    logic [WEIGHT_BITS-1:0] m_upper_weight;
    logic [OUT_BITS-1:0]    m_lower_px;
    logic [OUT_BITS-1:0]    m_lower_py;
    logic [WEIGHT_BITS-1:0] m_lower_weight;
    logic                   m_last_column;

    int mismatch_count;
    int columns_due;
    int columns_checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cols_left     = 0;
    int items_sent    = 0;
    int loads_sent    = 0;
    int steps_sent    = 0;

    antialiased_line_coverage_gen u_dut (.*);

    aaline_checker u_checker (.*);

    always begin
        #CLK_LOW  aclk = 1'b1;
        #CLK_HIGH aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    task automatic drive_transaction(input logic act,
                                     input logic [COORD_BITS-1:0] sx,
                                     input logic [COORD_BITS-1:0] sy,
                                     input logic [COORD_BITS-1:0] ex,
                                     input logic [COORD_BITS-1:0] ey);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_start_x <= sx;
        s_start_y <= sy;
        s_end_x   <= ex;
        s_end_y   <= ey;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic issue_load(input int sx, input int sy, input int ex, input int ey);
        int span;
        span = (ex > sx) ? ex - sx : sx - ex;
        if (((ey > sy) ? ey - sy : sy - ey) > span) begin
            span = (ey > sy) ? ey - sy : sy - ey;
        end
        drive_transaction(ACTION_LOAD, COORD_BITS'(sx), COORD_BITS'(sy),
                          COORD_BITS'(ex), COORD_BITS'(ey));
        cols_left = (span == 0) ? 2 : span + 1;
        loads_sent++;
        items_sent++;
    endtask

    task automatic issue_steps(input int count);
        repeat (count) begin
            drive_transaction(ACTION_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                              COORD_BITS'($urandom), COORD_BITS'($urandom));
            steps_sent++;
            if (cols_left > 0) begin
                cols_left--;
                items_sent++;
            end
        end
    endtask

    function automatic int shift_coord(input int c, input int d);
        int  r;
        bit  neg;
        neg = $urandom_range(1);
        r   = neg ? c - d : c + d;
        if (r < 0 || r > COORD_MAX) begin
            r = neg ? c + d : c - d;
        end
        return r;
    endfunction

    task automatic random_line();
        int sx, sy, major, minor;
        sx    = $urandom_range(COORD_MAX);
        sy    = $urandom_range(COORD_MAX);
        major = ($urandom_range(9) == 0) ? $urandom_range(100) : $urandom_range(12);
        minor = $urandom_range(major);
        if ($urandom_range(1)) begin
            issue_load(sx, sy, shift_coord(sx, major), shift_coord(sy, minor));
        end else begin
            issue_load(sx, sy, shift_coord(sx, minor), shift_coord(sy, major));
        end
        issue_steps(cols_left);
    endtask

    task automatic run_random(input int budget);
        int goal;
        int pick;
        goal = items_sent + budget;
        while (items_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                random_line();
            end else if (pick < 92) begin
                issue_load($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                           $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
                issue_steps($urandom_range(6));
            end else begin
                issue_steps($urandom_range(1, 3));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 55;
        issue_steps(1);
        issue_load(0, 0, 0, 0);
        issue_steps(2);
        issue_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        issue_steps(2);
        issue_load(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 1);
        issue_steps(2);
        issue_load(0, COORD_MAX, 3, COORD_MAX - 4);
        issue_steps(5);
        issue_load(0, 0, COORD_MAX, 2048);
        issue_steps(1);
        issue_load(100, 200, 103, 200);
        issue_steps(4);

        run_random(210);
        send_idle_pct = 55;
        recv_idle_pct = 18;
        run_random(210);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(210);
        s_valid <= 1'b0;

        while (columns_due != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d line loads and %0d step transactions, %0d columns compared,",
                 loads_sent, steps_sent, columns_checked);
        $display("with sender/receiver idle at 18/55, 55/18 and 0/0 percent.");
        if (mismatch_count == 0 && columns_due == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
